### rtl/core/ansi_escape_stream_parser_top_macros.svh
// assertion macros for the escape stream parser
// used by aesp_front and aesp_back
`ifndef ANSI_ESCAPE_STREAM_PARSER_TOP_MACROS_SVH
`define ANSI_ESCAPE_STREAM_PARSER_TOP_MACROS_SVH
`define AESP_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define AESP_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### rtl/core/aesp_pkg.sv
// package for the escape stream parser
// types, codes and the dec graphics table
package aesp_pkg;
  localparam int MaxParams = 16;
  localparam int PcW = $clog2(MaxParams + 1);
  localparam int PiW = $clog2(MaxParams);
  localparam int QDepth = 4;
  localparam int QaW = $clog2(QDepth);

  typedef enum logic [2:0] {
    ST_GROUND = 3'd0, ST_ESC = 3'd1, ST_ESCI = 3'd2, ST_CSI = 3'd3, ST_OSC = 3'd4, ST_DCS = 3'd5
  } pst_t;

  typedef enum logic [1:0] {BK_IDLE = 2'd0, BK_PARAM = 2'd1} bst_t;

  localparam logic [2:0] EV_GLYPH = 3'd0;
  localparam logic [2:0] EV_CTRL  = 3'd1;
  localparam logic [2:0] EV_ESCF  = 3'd2;
  localparam logic [2:0] EV_CSIP  = 3'd3;
  localparam logic [2:0] EV_OSCB  = 3'd4;
  localparam logic [2:0] EV_OSCE  = 3'd5;

  // one queued command: a single event, or a csi final that expands
  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] code;
    logic [7:0]  inter;
    logic [2:0]  flags;
    logic [PcW-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] code;
    logic [7:0]  inter;
    logic [15:0] value;
    logic [3:0]  index;
    logic [2:0]  flags;
    logic        last;
  } ev_t;

  function automatic logic [20:0] dec_gfx(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'h00A0;  5'd1: v = 16'h25C6;  5'd2: v = 16'h2592;  5'd3: v = 16'h2409;
      5'd4: v = 16'h240C;  5'd5: v = 16'h240D;  5'd6: v = 16'h240A;  5'd7: v = 16'h00B0;
      5'd8: v = 16'h00B1;  5'd9: v = 16'h2424;  5'd10: v = 16'h240B; 5'd11: v = 16'h2518;
      5'd12: v = 16'h2510; 5'd13: v = 16'h250C; 5'd14: v = 16'h2514; 5'd15: v = 16'h253C;
      5'd16: v = 16'h23BA; 5'd17: v = 16'h23BB; 5'd18: v = 16'h2500; 5'd19: v = 16'h23BC;
      5'd20: v = 16'h23BD; 5'd21: v = 16'h251C; 5'd22: v = 16'h2524; 5'd23: v = 16'h2534;
      5'd24: v = 16'h252C; 5'd25: v = 16'h2502; 5'd26: v = 16'h2264; 5'd27: v = 16'h2265;
      5'd28: v = 16'h03C0; 5'd29: v = 16'h2260; 5'd30: v = 16'h00A3; default: v = 16'h00B7;
    endcase
    return {5'd0, v};
  endfunction
endpackage

### rtl/core/ansi_escape_stream_parser_top.sv
// channel   dir  tdata fields (low bit up)
// in        in   data_byte[7:0]
// out       out  event_kind[2:0] code[23:3] intermediate[31:24] param_value[47:32]
//                param_index[51:48] private[52] greater[53] equal[54]; tlast = last
// cfg       in   osc_byte_limit[20:0]
// the front end decodes each byte combinationally into registered parse state; each event
// leaves through the output register; a csi final first reads the store, then emits one
// event per parameter; a four-entry command queue separates the two; input stalls when it
// is full, and inside a csi until the queue is empty and the back end is idle
// reset is synchronous, active low, and clears all control state
module ansi_escape_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // kind, code, intermediate, value, index, flags
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data    // osc_byte_limit
);
  import aesp_pkg::*;

  logic [20:0] lim_r;
  logic q_full, bk_idle, q_push, pw_we;
  cmd_t q_cmd;
  logic [PiW-1:0] pw_addr, pr_addr;
  logic [15:0] pw_data, pr_data;
  ev_t ev;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) lim_r <= 21'h100000;
    else if (cfg_valid) lim_r <= cfg_data;
  end

  aesp_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .b(in_tdata),
    .osc_limit(lim_r), .q_full, .bk_idle, .q_push, .q_cmd, .pw_we, .pw_addr, .pw_data
  );

  aesp_ram #(.Width(16), .Depth(MaxParams)) u_ram (
    .clk, .we(pw_we), .waddr(pw_addr), .wdata(pw_data), .raddr(pr_addr), .rdata(pr_data)
  );

  aesp_back u_back (
    .clk, .rst_n, .q_push, .q_cmd, .q_full, .bk_idle, .pr_addr, .pr_data,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_ev(ev)
  );

  assign out_tdata = {1'b0, ev.flags[2], ev.flags[1], ev.flags[0], ev.index, ev.value,
                      ev.inter, ev.code, ev.kind};
  assign out_tlast = ev.last;
endmodule

### rtl/core/aesp_ram.sv
// generic ram, one write port, one registered read port
// no dependencies
module aesp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/aesp_front.sv
// front end: byte classification, utf-8, charset and parse state
// depends on aesp_pkg; writes the parameter store
module aesp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          b,
  input  logic [20:0]         osc_limit,
  input  logic                q_full,
  input  logic                bk_idle,
  output logic                q_push,
  output aesp_pkg::cmd_t      q_cmd,
  output logic                pw_we,
  output logic [aesp_pkg::PiW-1:0] pw_addr,
  output logic [15:0]         pw_data
);
  import aesp_pkg::*;
  `include "ansi_escape_stream_parser_top_macros.svh"

  pst_t st_r, st_nxt;
  logic [PcW-1:0] pc_r, pc_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic hd_r, hd_nxt;
  logic [7:0] lead_r, lead_nxt, li_r, li_nxt;
  logic [2:0] mk_r, mk_nxt, cs_r, cs_nxt;
  logic [20:0] acc_r, acc_nxt, oc_r, oc_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic se_r, se_nxt;
  logic go, ev, gl;
  logic [20:0] gcp, mcp;
  logic [19:0] mul;
  logic gfx;

  // the store is shared, so bytes inside a csi wait until the queue is empty and the back end has expanded the last csi
  assign in_ready = !q_full && (st_r != ST_CSI || bk_idle);
  assign go = in_valid && in_ready;
  assign gfx = cs_r[2] ? cs_r[1] : cs_r[0];
  assign mul = {1'b0, cp_r, 3'd0} + {3'd0, cp_r, 1'b0} + {12'd0, (b - 8'h30)};
  always_comb begin
    mcp = gcp;
    if (gfx && gcp >= 21'h5F && gcp <= 21'h7E) mcp = dec_gfx(5'(gcp - 21'h5F));
  end

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; cp_nxt = cp_r; hd_nxt = hd_r; lead_nxt = lead_r;
    li_nxt = li_r; mk_nxt = mk_r; cs_nxt = cs_r; acc_nxt = acc_r; rem_nxt = rem_r;
    se_nxt = se_r; oc_nxt = oc_r;
    ev = 1'b0; gl = 1'b0; gcp = '0;
    q_cmd = '{kind: EV_CTRL, code: {13'd0, b}, inter: 8'd0, flags: 3'd0, count: '0};
    pw_we = 1'b0; pw_addr = pc_r[PiW-1:0]; pw_data = hd_r ? cp_r : 16'd0;
    case (st_r)
      ST_ESC: begin
        if (b == 8'h5B) begin
          pc_nxt = '0; cp_nxt = '0; hd_nxt = 1'b0; li_nxt = '0; mk_nxt = '0;
          st_nxt = ST_CSI;
        end else if (b == 8'h5D || b == 8'h50) begin
          oc_nxt = '0; se_nxt = 1'b0;
          st_nxt = (b == 8'h5D) ? ST_OSC : ST_DCS;
        end else if (b == 8'h28 || b == 8'h29 || b == 8'h23 || b == 8'h2A || b == 8'h2B) begin
          lead_nxt = b; st_nxt = ST_ESCI;
        end else begin
          ev = 1'b1; q_cmd.kind = EV_ESCF; st_nxt = ST_GROUND;
        end
      end
      ST_ESCI: begin
        if (lead_r == 8'h28) cs_nxt[0] = (b == 8'h30);
        else if (lead_r == 8'h29) cs_nxt[1] = (b == 8'h30);
        ev = 1'b1; q_cmd.kind = EV_ESCF; q_cmd.inter = lead_r; st_nxt = ST_GROUND;
      end
      ST_CSI: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          cp_nxt = (mul > 20'd65535) ? 16'hFFFF : mul[15:0];
          hd_nxt = 1'b1;
        end else if (b == 8'h3B) begin
          pw_we = (pc_r < PcW'(MaxParams));
          if (pw_we) pc_nxt = pc_r + 1'b1;
          cp_nxt = '0; hd_nxt = 1'b0;
        end else if (b >= 8'h3C && b <= 8'h3F) begin
          mk_nxt[0] = (b == 8'h3F);
          if (b == 8'h3E) mk_nxt[1] = 1'b1;
          if (b == 8'h3D) mk_nxt[2] = 1'b1;
        end else if (b >= 8'h20 && b <= 8'h2F) begin
          li_nxt = b;
        end else if (b == 8'h1B) begin
          st_nxt = ST_ESC;
        end else if (b < 8'h20) begin
          ev = 1'b1;
          if (b == 8'h0E) cs_nxt[2] = 1'b1;
          if (b == 8'h0F) cs_nxt[2] = 1'b0;
        end else begin
          pw_we = (pc_r < PcW'(MaxParams));
          ev = 1'b1; q_cmd.kind = EV_CSIP; q_cmd.inter = li_r; q_cmd.flags = mk_r;
          q_cmd.count = pw_we ? pc_r + 1'b1 : pc_r;
          pc_nxt = q_cmd.count; cp_nxt = '0; hd_nxt = 1'b0;
          st_nxt = ST_GROUND;
        end
      end
      ST_OSC, ST_DCS: begin
        if (b == 8'h07 || (b == 8'h5C && se_r)) begin
          se_nxt = 1'b0; st_nxt = ST_GROUND;
          ev = (st_r == ST_OSC); q_cmd.kind = EV_OSCE;
        end else if (b == 8'h1B) begin
          se_nxt = 1'b1;
        end else begin
          se_nxt = 1'b0;
          if (st_r == ST_OSC && b >= 8'h20 && oc_r < osc_limit) begin
            oc_nxt = oc_r + 1'b1; ev = 1'b1; q_cmd.kind = EV_OSCB;
          end
        end
      end
      default: begin
        if (b == 8'h1B) begin
          st_nxt = ST_ESC;
        end else if (b < 8'h20) begin
          ev = 1'b1;
          if (b == 8'h0E) cs_nxt[2] = 1'b1;
          if (b == 8'h0F) cs_nxt[2] = 1'b0;
        end else if (b != 8'h7F) begin
          if (rem_r != 2'd0 && b[7:6] == 2'b10) begin
            acc_nxt = {acc_r[14:0], b[5:0]};
            rem_nxt = rem_r - 1'b1;
            if (rem_nxt == 2'd0) begin gl = 1'b1; gcp = acc_nxt; end
          end else begin
            rem_nxt = 2'd0;
            if (!b[7]) begin gl = 1'b1; gcp = {13'd0, b}; end
            else if (b[7:5] == 3'b110) begin acc_nxt = {16'd0, b[4:0]}; rem_nxt = 2'd1; end
            else if (b[7:4] == 4'b1110) begin acc_nxt = {17'd0, b[3:0]}; rem_nxt = 2'd2; end
            else if (b[7:3] == 5'b11110) begin acc_nxt = {18'd0, b[2:0]}; rem_nxt = 2'd3; end
            else begin gl = 1'b1; gcp = 21'hFFFD; end
          end
          if (gl) begin ev = 1'b1; q_cmd.kind = EV_GLYPH; q_cmd.code = mcp; end
        end
      end
    endcase
    q_push = go && ev;
    pw_we = go && pw_we;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_GROUND; pc_r <= '0; cp_r <= '0; hd_r <= 1'b0; lead_r <= '0; li_r <= '0;
      mk_r <= '0; cs_r <= '0; acc_r <= '0; rem_r <= '0; se_r <= 1'b0; oc_r <= '0;
    end else if (go) begin
      st_r <= st_nxt; pc_r <= pc_nxt; cp_r <= cp_nxt; hd_r <= hd_nxt; lead_r <= lead_nxt;
      li_r <= li_nxt; mk_r <= mk_nxt; cs_r <= cs_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt;
      se_r <= se_nxt; oc_r <= oc_nxt;
    end
  end

  `AESP_ASSERT_IMP(a_pc_bound, clk, rst_n, 1'b1, pc_r <= PcW'(MaxParams), "param count over")
  `AESP_ASSERT_IMP(a_push_ready, clk, rst_n, q_push, !q_full, "push into full queue")
  `AESP_ASSERT_IMP(a_pw_csi, clk, rst_n, pw_we, st_r == ST_CSI, "store write outside csi")
endmodule

### rtl/core/aesp_back.sv
// back end: queue of commands and event expansion into the output register
// depends on aesp_pkg and aesp_ram via the top level read port
module aesp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_push,
  input  aesp_pkg::cmd_t      q_cmd,
  output logic                q_full,
  output logic                bk_idle,
  output logic [aesp_pkg::PiW-1:0] pr_addr,
  input  logic [15:0]         pr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aesp_pkg::ev_t       out_ev
);
  import aesp_pkg::*;
  `include "ansi_escape_stream_parser_top_macros.svh"

  cmd_t q_r [QDepth];
  logic [QaW:0] wp_r, rp_r;
  bst_t bs_r, bs_nxt;
  cmd_t cur_r, cur_nxt;
  logic [PcW-1:0] ix_r, ix_nxt;
  logic pend_r, pend_nxt;
  logic ov_r, ov_nxt;
  ev_t oe_r, oe_nxt;
  logic pop, slot, q_empty;
  cmd_t head;

  assign q_full = (wp_r[QaW] != rp_r[QaW]) && (wp_r[QaW-1:0] == rp_r[QaW-1:0]);
  assign q_empty = (wp_r == rp_r);
  assign bk_idle = q_empty && (bs_r == BK_IDLE);
  assign head = q_r[rp_r[QaW-1:0]];
  assign slot = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_ev = oe_r;
  assign pr_addr = ix_nxt[PiW-1:0];

  always_comb begin
    bs_nxt = bs_r; cur_nxt = cur_r; ix_nxt = ix_r; pend_nxt = 1'b0; pop = 1'b0;
    ov_nxt = ov_r && !out_ready; oe_nxt = oe_r;
    case (bs_r)
      BK_PARAM: begin
        if (pend_r) begin
          if (slot) begin
            ov_nxt = 1'b1;
            oe_nxt = '{kind: EV_CSIP, code: cur_r.code, inter: cur_r.inter, value: pr_data,
                       index: 4'(ix_r), flags: cur_r.flags, last: (ix_r + 1'b1 == cur_r.count)};
            ix_nxt = ix_r + 1'b1;
            if (ix_nxt == cur_r.count) bs_nxt = BK_IDLE;
            else pend_nxt = 1'b1;
          end else pend_nxt = 1'b1;
        end else pend_nxt = 1'b1;
      end
      default: begin
        if (!q_empty && slot) begin
          pop = 1'b1;
          if (head.kind == EV_CSIP) begin
            cur_nxt = head; ix_nxt = '0;
            if (head.count != '0) begin bs_nxt = BK_PARAM; pend_nxt = 1'b1; end
          end else begin
            ov_nxt = 1'b1;
            oe_nxt = '{kind: head.kind, code: head.code, inter: head.inter, value: 16'd0,
                       index: 4'd0, flags: 3'd0, last: 1'b1};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_push) q_r[wp_r[QaW-1:0]] <= q_cmd;
    oe_r <= oe_nxt; cur_r <= cur_nxt;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; bs_r <= BK_IDLE; ix_r <= '0; pend_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (q_push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      bs_r <= bs_nxt; ix_r <= ix_nxt; pend_r <= pend_nxt; ov_r <= ov_nxt;
    end
  end

  `AESP_ASSERT_IMP(a_no_over, clk, rst_n, q_full, !q_push, "queue overflow")
  `AESP_ASSERT_NXT(a_hold, clk, rst_n, ov_r && !out_ready, ov_r && $stable(oe_r), "out dropped")
  `AESP_ASSERT_IMP(a_ix, clk, rst_n, bs_r == BK_PARAM, ix_r < cur_r.count, "index past count")
endmodule
